// File: rtl/core/nmfr_pkg.sv
// ----------------------------------------------------------------------------
// nmfr_pkg
// Types and constants shared by the NMEA sentence framer.
// ----------------------------------------------------------------------------
`default_nettype none

package nmfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_BODY  = 2'd2,
    PH_CSUM  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_PARSING = 2'd1,
    ST_READY   = 2'd2,
    ST_WRONG   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TYPE = 2'd1,
    KIND_BODY = 2'd2,
    KIND_CSUM = 2'd3
  } kind_e;

  localparam logic [7:0] CharStart = 8'h24;  // '$'
  localparam logic [7:0] CharStop  = 8'h2A;  // '*'
  localparam logic [7:0] CharSep   = 8'h2C;  // ','
  localparam logic [7:0] PrintLo   = 8'h20;
  localparam logic [7:0] PrintHi   = 8'h7E;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // ASCII hex digit decode; anything else reads as zero and not ok
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/nmea_sentence_framer.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Byte-serial NMEA 0183 sentence framer with XOR checksum check.
//
// Usage: feed received characters on the in channel (rx_byte_i, valid/ready).
// Every accepted byte produces exactly one result beat on the out channel:
// parser status, byte classification, the echoed byte, its position within
// the type or body field, the running XOR and, on the second checksum digit,
// the decoded received checksum.
// The result of a byte is registered and presented in the cycle after its accept.
// Throughput: one byte per cycle while the receiver does not stall; the
// framer state updates combinationally from input port to result register.
// A stalled receiver holds the result register; in_ready_o is high whenever
// that register is empty or being drained in the same cycle, so the input
// side keeps flowing under a draining output.
// Reset: the framer returns to hunting for '$' with a cleared sum, and no
// result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer #(
  parameter int unsigned TYPE_MAX = 8,
  parameter int unsigned BODY_MAX = 128
) (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic [7:0] rx_byte_i,
  input  wire  logic       in_valid_i,
  output logic             in_ready_o,
  output logic [1:0]       status_o,
  output logic [1:0]       byte_kind_o,
  output logic [7:0]       char_out_o,
  output logic [6:0]       char_index_o,
  output logic [7:0]       sum_computed_o,
  output logic [7:0]       sum_received_o,
  output logic             out_valid_o,
  input  wire  logic       out_ready_i
);

  import nmfr_pkg::*;

  localparam logic [7:0] TypeLast = 8'(TYPE_MAX - 1);
  localparam logic [7:0] BodyLim  = 8'(BODY_MAX);

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] pos_q, pos_d;
  logic [3:0] hexhi_q, hexhi_d;
  logic       hexok_q, hexok_d;

  logic       out_valid_q;
  status_e    status_d, status_q;
  kind_e      kind_d, kind_q;
  logic [7:0] char_q;
  logic [6:0] idx_d, idx_q;
  logic [7:0] sum_d, sum_q;
  logic [7:0] rsum_d, rsum_q;

  logic       accept;
  logic       printable;
  hex_t       hx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign printable  = (rx_byte_i >= PrintLo) && (rx_byte_i <= PrintHi);
  assign hx         = hex_decode(rx_byte_i);

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    pos_d    = pos_q;
    hexhi_d  = hexhi_q;
    hexok_d  = hexok_q;
    status_d = ST_PARSING;
    kind_d   = KIND_NONE;
    idx_d    = 7'd0;
    sum_d    = xor_q;
    rsum_d   = 8'd0;

    if (phase_q != PH_HUNT && !printable) begin
      status_d = ST_WRONG;
      phase_d  = PH_HUNT;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == CharStart) begin
            phase_d = PH_TYPE;
          end else begin
            status_d = ST_IGNORED;
          end
        end
        PH_TYPE: begin
          if (rx_byte_i == CharSep) begin
            xor_d   = xor_q ^ rx_byte_i;
            sum_d   = xor_d;
            pos_d   = 8'd0;
            phase_d = PH_BODY;
          end else if (pos_q >= TypeLast) begin
            status_d = ST_WRONG;
            phase_d  = PH_HUNT;
          end else begin
            kind_d = KIND_TYPE;
            idx_d  = pos_q[6:0];
            pos_d  = pos_q + 8'd1;
            xor_d  = xor_q ^ rx_byte_i;
            sum_d  = xor_d;
          end
        end
        PH_BODY: begin
          if (rx_byte_i == CharStop) begin
            pos_d   = 8'd0;
            hexhi_d = 4'd0;
            hexok_d = 1'b1;
            phase_d = PH_CSUM;
          end else if (pos_q >= BodyLim) begin
            status_d = ST_WRONG;
            phase_d  = PH_HUNT;
          end else begin
            kind_d = KIND_BODY;
            idx_d  = pos_q[6:0];
            pos_d  = pos_q + 8'd1;
            xor_d  = xor_q ^ rx_byte_i;
            sum_d  = xor_d;
          end
        end
        PH_CSUM: begin
          kind_d = KIND_CSUM;
          if (pos_q == 8'd0) begin
            hexhi_d = hx.value;
            hexok_d = hexok_q & hx.ok;
            pos_d   = 8'd1;
          end else begin
            idx_d    = 7'd1;
            rsum_d   = {hexhi_q, hx.value};
            status_d = (hexok_q && hx.ok && rsum_d == xor_q) ? ST_READY : ST_WRONG;
            phase_d  = PH_HUNT;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end

    // leaving a frame clears everything for the next hunt
    if (phase_d == PH_HUNT) begin
      xor_d   = 8'd0;
      pos_d   = 8'd0;
      hexhi_d = 4'd0;
      hexok_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      xor_q   <= 8'd0;
      pos_q   <= 8'd0;
      hexhi_q <= 4'd0;
      hexok_q <= 1'b1;
    end else if (accept) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      pos_q   <= pos_d;
      hexhi_q <= hexhi_d;
      hexok_q <= hexok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload: load on accept, hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      kind_q   <= kind_d;
      char_q   <= rx_byte_i;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      rsum_q   <= rsum_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign byte_kind_o    = kind_q;
  assign char_out_o     = char_q;
  assign char_index_o   = idx_q;
  assign sum_computed_o = sum_q;
  assign sum_received_o = rsum_q;

  // a good sentence is only ever reported on the last checksum digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_READY |->
      kind_q == KIND_CSUM && idx_q == 7'd1 && sum_q == rsum_q)
    else $error("ready result without matching checksum beat");

  // framing beats carry no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_NONE |-> idx_q == 7'd0)
    else $error("framing beat with nonzero index");

  // outside a frame the running sum stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> xor_q == 8'd0 && pos_q == 8'd0 && hexok_q)
    else $error("hunt state not clean");

  // every accepted byte leaves a result beat behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nmea_sentence_framer. Feeds short directed byte
// runs, then random sentences with random content, mixed with line noise and
// broken sentences. The expected result of every accepted byte comes from a
// behavioral framer in the scoreboard and is checked field by field against
// the result beats, with random stalls on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import nmfr_pkg::*;

  localparam int unsigned TypeMax     = 8;
  localparam int unsigned BodyMax     = 128;
  localparam int          RandomItems = 850;
  localparam int          LongHold    = 200;
  localparam int          SettleCycles = 8;
  localparam int          CycleLimit  = 400000;

  typedef enum int {
    CS_UPPER,
    CS_LOWER,
    CS_WRONG,
    CS_BAD_HI,
    CS_BAD_LO
  } csum_mode_e;

  typedef struct packed {
    status_e    status;
    kind_e      kind;
    logic [7:0] chr;
    logic [6:0] idx;
    logic [7:0] sum_calc;
    logic [7:0] sum_rx;
  } frame_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] status_o;
  logic [1:0] byte_kind_o;
  logic [7:0] char_out_o;
  logic [6:0] char_index_o;
  logic [7:0] sum_computed_o;
  logic [7:0] sum_received_o;
  logic       out_valid_o;

  int unsigned cycles       = 0;
  int          sent_count   = 0;
  bit          hold_req     = 1'b0;

  // {ok, value} of an ASCII hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    return 5'd0;
  endfunction

  class framer_scoreboard;
    phase_e          ph;
    logic [7:0]      xsum;
    logic [7:0]      fpos;
    logic [3:0]      hi_nib;
    logic            hex_good;
    frame_result_t   awaited_q[$];
    int              mismatches;

    function new();
      mismatches = 0;
      rehunt();
    endfunction

    function void rehunt();
      ph       = PH_HUNT;
      xsum     = '0;
      fpos     = '0;
      hi_nib   = '0;
      hex_good = 1'b1;
    endfunction

    function status_e note_byte(input logic [7:0] c);
      frame_result_t r;
      logic [4:0]    d;
      r.status   = ST_PARSING;
      r.kind     = KIND_NONE;
      r.chr      = c;
      r.idx      = '0;
      r.sum_rx   = '0;
      r.sum_calc = xsum;
      if (ph != PH_HUNT && (c < PrintLo || c > PrintHi)) begin
        r.status = ST_WRONG;
        rehunt();
      end else begin
        case (ph)
          PH_HUNT: begin
            if (c == CharStart) begin
              rehunt();
              ph = PH_TYPE;
            end else begin
              r.status = ST_IGNORED;
            end
          end
          PH_TYPE: begin
            if (c == CharSep) begin
              xsum = xsum ^ c;
              fpos = '0;
              ph   = PH_BODY;
            end else if (int'(fpos) + 1 >= int'(TypeMax)) begin
              r.status = ST_WRONG;
              rehunt();
            end else begin
              r.kind = KIND_TYPE;
              r.idx  = fpos[6:0];
              fpos   = fpos + 8'd1;
              xsum   = xsum ^ c;
            end
            r.sum_calc = (r.status == ST_WRONG) ? r.sum_calc : xsum;
          end
          PH_BODY: begin
            if (c == CharStop) begin
              fpos     = '0;
              hi_nib   = '0;
              hex_good = 1'b1;
              ph       = PH_CSUM;
            end else if (int'(fpos) >= int'(BodyMax)) begin
              r.status = ST_WRONG;
              rehunt();
            end else begin
              r.kind = KIND_BODY;
              r.idx  = fpos[6:0];
              fpos   = fpos + 8'd1;
              xsum   = xsum ^ c;
            end
            r.sum_calc = (r.status == ST_WRONG) ? r.sum_calc : xsum;
          end
          default: begin
            d      = hex_nibble(c);
            r.kind = KIND_CSUM;
            if (fpos == 8'd0) begin
              hi_nib   = d[3:0];
              hex_good = hex_good & d[4];
              fpos     = 8'd1;
            end else begin
              r.idx    = 7'd1;
              r.sum_rx = {hi_nib, d[3:0]};
              r.status = (hex_good && d[4] && r.sum_rx == xsum) ? ST_READY : ST_WRONG;
              rehunt();
            end
          end
        endcase
      end
      awaited_q.push_back(r);
      return r.status;
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (awaited_q.size() == 0) begin
        flag($sformatf("unexpected result beat for byte %h at cycle %0d", got.chr, cycles));
        return;
      end
      want = awaited_q.pop_front();
      if (got !== want) begin
        flag($sformatf({"mismatch at cycle %0d: got st=%0d kind=%0d chr=%h idx=%0d ",
                        "sum=%h rx=%h, want st=%0d kind=%0d chr=%h idx=%0d sum=%h rx=%h"},
                       cycles, got.status, got.kind, got.chr, got.idx, got.sum_calc,
                       got.sum_rx, want.status, want.kind, want.chr, want.idx,
                       want.sum_calc, want.sum_rx));
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  framer_scoreboard sb = new();

  nmea_sentence_framer #(
    .TYPE_MAX(TypeMax),
    .BODY_MAX(BodyMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .status_o      (status_o),
    .byte_kind_o   (byte_kind_o),
    .char_out_o    (char_out_o),
    .char_index_o  (char_index_o),
    .sum_computed_o(sum_computed_o),
    .sum_received_o(sum_received_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // check every result beat taken by the receiver
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status   = status_e'(status_o);
      got.kind     = kind_e'(byte_kind_o);
      got.chr      = char_out_o;
      got.idx      = char_index_o;
      got.sum_calc = sum_computed_o;
      got.sum_rx   = sum_received_o;
      sb.check_result(got);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(32, 126));
    end while (hex_nibble(c) != 5'd0);
    return c;
  endfunction

  function automatic logic [7:0] non_print_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(127, 255));
  endfunction

  // offer one beat; valid stays up after the accept until the next call
  task automatic send_byte(input logic [7:0] b, input bit idle_ok);
    int gap;
    gap = idle_ok ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_byte_i  <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(sb.note_byte(b));
    sent_count++;
  endtask

  task automatic send_sentence(input int type_len, input int body_len,
                               input csum_mode_e mode, input bit corrupt,
                               input bit idle_ok);
    logic [7:0] line_q[$];
    logic [7:0] c;
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    bit         lower;
    int         pos;
    sum = '0;
    line_q.push_back(CharStart);
    for (int i = 0; i < type_len; i++) begin
      do c = 8'($urandom_range(32, 126)); while (c == CharSep);
      line_q.push_back(c);
      sum ^= c;
    end
    line_q.push_back(CharSep);
    sum ^= CharSep;
    for (int i = 0; i < body_len; i++) begin
      do c = 8'($urandom_range(32, 126)); while (c == CharStop);
      line_q.push_back(c);
      sum ^= c;
    end
    line_q.push_back(CharStop);
    if (mode == CS_WRONG) sum ^= 8'($urandom_range(1, 255));
    lower = (mode == CS_LOWER) || (mode != CS_UPPER && $urandom_range(0, 1) == 1);
    hi = (mode == CS_BAD_HI) ? non_hex_char() : hex_char(sum[7:4], lower);
    lo = (mode == CS_BAD_LO) ? non_hex_char() : hex_char(sum[3:0], lower);
    line_q.push_back(hi);
    line_q.push_back(lo);
    if (corrupt) begin
      pos = $urandom_range(1, line_q.size() - 1);
      line_q[pos] = non_print_char();
    end
    foreach (line_q[i]) send_byte(line_q[i], idle_ok);
  endtask

  // receiver: short and long runs of ready, random stalls, one long hold-off
  initial begin
    int run;
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int         r;
    int         tl;
    int         bl;
    csum_mode_e mode;
    bit         drained;
    bit         idle_ok;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // line noise outside a frame, field extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h41, 1'b1);
    // '$' as the type character is data, not a restart
    send_byte(CharStart, 1'b1);
    send_byte(CharStart, 1'b1);
    send_byte(CharSep, 1'b1);
    send_byte(CharStop, 1'b1);
    send_byte(8'h30, 1'b1);
    send_byte(8'h38, 1'b1);
    send_sentence(1, 1, CS_LOWER, 1'b0, 1'b1);
    send_sentence(0, 0, CS_WRONG, 1'b0, 1'b1);
    send_sentence(0, 0, CS_BAD_HI, 1'b0, 1'b1);
    // non-printable inside a frame
    send_byte(CharStart, 1'b1);
    send_byte(8'h1F, 1'b1);
    // overlong type: the last character trips the limit
    send_byte(CharStart, 1'b1);
    repeat (TypeMax) send_byte(8'h47, 1'b1);

    hold_req = 1'b1;
    drained  = 1'b0;
    while (sent_count < RandomItems) begin
      if (!drained && sent_count >= RandomItems / 2) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      idle_ok = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), idle_ok);
      end else begin
        tl = ($urandom_range(0, 99) < 85) ? $urandom_range(0, TypeMax - 1)
                                          : $urandom_range(TypeMax, TypeMax + 1);
        r = $urandom_range(0, 99);
        if (r < 94) bl = $urandom_range(0, 16);
        else if (r < 98) bl = $urandom_range(100, BodyMax);
        else bl = $urandom_range(BodyMax + 1, BodyMax + 3);
        r = $urandom_range(0, 99);
        if (r < 60) mode = CS_UPPER;
        else if (r < 75) mode = CS_LOWER;
        else if (r < 85) mode = CS_WRONG;
        else if (r < 93) mode = CS_BAD_HI;
        else mode = CS_BAD_LO;
        send_sentence(tl, bl, mode, $urandom_range(0, 99) < 8, idle_ok);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
